FILE: sv/servo_motion_sequencer_assert.svh
// Assertion macros shared by the servo motion sequencer modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef SERVO_MOTION_SEQUENCER_ASSERT_SVH
`define SERVO_MOTION_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("servo motion sequencer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("servo motion sequencer: next-cycle check failed");

`endif

FILE: sv/sms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sms_pkg;

	localparam int unsigned ANGLE_W    = 8;
	localparam int unsigned PROG_W     = 4;
	localparam int unsigned INTERVAL_W = 8;
	localparam int unsigned ELAPSED_W  = 9;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [PROG_W-1:0] PROG_IDLE          = 4'd0;
	localparam logic [PROG_W-1:0] PROG_MOVING        = 4'd1;
	localparam logic [PROG_W-1:0] PROG_FLIP          = 4'd2;
	localparam logic [PROG_W-1:0] PROG_RETURN        = 4'd3;
	localparam logic [PROG_W-1:0] PROG_RETURN_VSLOW  = 4'd4;
	localparam logic [PROG_W-1:0] PROG_THREE_1       = 4'd5;
	localparam logic [PROG_W-1:0] PROG_THREE_2       = 4'd6;
	localparam logic [PROG_W-1:0] PROG_THREE_3       = 4'd7;
	localparam logic [PROG_W-1:0] PROG_FLIP_SLOW     = 4'd8;
	localparam logic [PROG_W-1:0] PROG_FLIP_VSLOW    = 4'd9;
	localparam logic [PROG_W-1:0] PROG_LAST          = PROG_FLIP_VSLOW;

	localparam logic [CFG_IDX_W-1:0] REG_REST_ANGLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_ANGLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_INTV    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_INTV    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VSLOW_INTV   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DEGREES = 3'd5;

	localparam logic [ANGLE_W-1:0]    ANGLE_MID_LOW    = 8'd130;
	localparam logic [ANGLE_W-1:0]    ANGLE_MID_HIGH   = 8'd160;
	localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX      = 9'd511;

	localparam logic [ANGLE_W-1:0]    RST_REST_ANGLE   = 8'd170;
	localparam logic [ANGLE_W-1:0]    RST_FLIP_ANGLE   = 8'd85;
	localparam logic [INTERVAL_W-1:0] RST_FAST_INTV    = 8'd10;
	localparam logic [INTERVAL_W-1:0] RST_SLOW_INTV    = 8'd30;
	localparam logic [INTERVAL_W-1:0] RST_VSLOW_INTV   = 8'd50;
	localparam logic [ANGLE_W-1:0]    RST_STEP_DEGREES = 8'd1;

	typedef struct packed {
		logic [ANGLE_W-1:0]    rest_angle;
		logic [ANGLE_W-1:0]    flip_angle;
		logic [INTERVAL_W-1:0] fast_interval;
		logic [INTERVAL_W-1:0] slow_interval;
		logic [INTERVAL_W-1:0] very_slow_interval;
		logic [ANGLE_W-1:0]    step_degrees;
	} cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] arm_angle;
		logic               angle_written;
		logic               step_finished;
		logic [PROG_W-1:0]  program_now;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/sms_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module sms_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sms_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sms_pkg::cfg_t                        cfg
);
	import sms_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_angle         <= RST_REST_ANGLE;
			cfg_q.flip_angle         <= RST_FLIP_ANGLE;
			cfg_q.fast_interval      <= RST_FAST_INTV;
			cfg_q.slow_interval      <= RST_SLOW_INTV;
			cfg_q.very_slow_interval <= RST_VSLOW_INTV;
			cfg_q.step_degrees       <= RST_STEP_DEGREES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REST_ANGLE:   cfg_q.rest_angle         <= cfg_data;
				REG_FLIP_ANGLE:   cfg_q.flip_angle         <= cfg_data;
				REG_FAST_INTV:    cfg_q.fast_interval      <= cfg_data;
				REG_SLOW_INTV:    cfg_q.slow_interval      <= cfg_data;
				REG_VSLOW_INTV:   cfg_q.very_slow_interval <= cfg_data;
				REG_STEP_DEGREES: cfg_q.step_degrees       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: sv/sms_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "servo_motion_sequencer_assert.svh"
module sms_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         proc,
	input  wire logic                         mode,
	input  wire logic [sms_pkg::PROG_W-1:0]   program_request,
	input  wire sms_pkg::cfg_t                cfg,
	output sms_pkg::result_t                  res
);
	import sms_pkg::*;

	logic [ANGLE_W-1:0]    angle_q;
	logic [PROG_W-1:0]     prog_cur_q;
	logic [PROG_W-1:0]     prog_next_q;
	logic [ANGLE_W-1:0]    target_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [ELAPSED_W-1:0]  elapsed_q;

	logic [ANGLE_W-1:0]    angle_d;
	logic [PROG_W-1:0]     prog_cur_d;
	logic [PROG_W-1:0]     prog_next_d;
	logic [ANGLE_W-1:0]    target_d;
	logic [INTERVAL_W-1:0] interval_d;
	logic [ELAPSED_W-1:0]  elapsed_d;
	logic [ELAPSED_W-1:0]  elapsed_inc;
	logic [ANGLE_W-1:0]    step;
	logic [ANGLE_W-1:0]    distance;
	logic                  written;
	logic                  finished;

	always_comb begin
		angle_d     = angle_q;
		prog_cur_d  = prog_cur_q;
		prog_next_d = prog_next_q;
		target_d    = target_q;
		interval_d  = interval_q;
		elapsed_d   = elapsed_q;
		written     = 1'b0;
		finished    = 1'b0;
		step        = (cfg.step_degrees == '0) ? ANGLE_W'(1) : cfg.step_degrees;
		distance    = (angle_q > target_q) ? angle_q - target_q : target_q - angle_q;
		elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + ELAPSED_W'(1) : elapsed_q;

		if (mode) begin
			if (program_request <= PROG_LAST) begin
				prog_cur_d = program_request;
			end
		end else begin
			elapsed_d = elapsed_inc;
			if (prog_cur_q == PROG_MOVING && elapsed_inc > {1'b0, interval_q}) begin
				elapsed_d = '0;
				if (angle_q != target_q) begin
					written = 1'b1;
					if (distance > step) begin
						angle_d = (angle_q > target_q) ? angle_q - step : angle_q + step;
					end else begin
						angle_d = target_q;
					end
				end
				if (angle_d == target_q) begin
					finished   = 1'b1;
					prog_cur_d = prog_next_q;
				end
			end
		end

		case (prog_cur_d)
			PROG_FLIP: begin
				target_d = cfg.flip_angle; interval_d = cfg.fast_interval;
				prog_next_d = PROG_IDLE; prog_cur_d = PROG_MOVING;
			end
			PROG_RETURN: begin
				target_d = cfg.rest_angle; interval_d = cfg.fast_interval;
				prog_next_d = PROG_IDLE; prog_cur_d = PROG_MOVING;
			end
			PROG_RETURN_VSLOW: begin
				target_d = cfg.rest_angle; interval_d = cfg.very_slow_interval;
				prog_next_d = PROG_IDLE; prog_cur_d = PROG_MOVING;
			end
			PROG_THREE_1: begin
				target_d = ANGLE_MID_LOW; interval_d = cfg.fast_interval;
				prog_next_d = PROG_THREE_2; prog_cur_d = PROG_MOVING;
			end
			PROG_THREE_2: begin
				target_d = ANGLE_MID_HIGH; interval_d = cfg.fast_interval;
				prog_next_d = PROG_THREE_3; prog_cur_d = PROG_MOVING;
			end
			PROG_THREE_3: begin
				target_d = cfg.flip_angle; interval_d = cfg.fast_interval;
				prog_next_d = PROG_RETURN; prog_cur_d = PROG_MOVING;
			end
			PROG_FLIP_SLOW: begin
				target_d = cfg.flip_angle; interval_d = cfg.slow_interval;
				prog_next_d = PROG_IDLE; prog_cur_d = PROG_MOVING;
			end
			PROG_FLIP_VSLOW: begin
				target_d = cfg.flip_angle; interval_d = cfg.very_slow_interval;
				prog_next_d = PROG_IDLE; prog_cur_d = PROG_MOVING;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q     <= RST_REST_ANGLE;
			prog_cur_q  <= PROG_IDLE;
			prog_next_q <= PROG_IDLE;
			target_q    <= '0;
			interval_q  <= '0;
			elapsed_q   <= '0;
		end else if (proc) begin
			angle_q     <= angle_d;
			prog_cur_q  <= prog_cur_d;
			prog_next_q <= prog_next_d;
			target_q    <= target_d;
			interval_q  <= interval_d;
			elapsed_q   <= elapsed_d;
		end
	end

	assign res.arm_angle     = angle_d;
	assign res.angle_written = written;
	assign res.step_finished = finished;
	assign res.program_now   = prog_cur_d;

	`SMS_ASSERT_IMPL(a_prog_settled, 1'b1, prog_cur_q == PROG_IDLE || prog_cur_q == PROG_MOVING)
	`SMS_ASSERT_NEXT(a_write_moves, proc && written, angle_q != $past(angle_q))
	`SMS_ASSERT_NEXT(a_finish_on_target, proc && finished, angle_q == $past(target_q))
	`SMS_ASSERT_NEXT(a_idle_holds, !proc, $stable(angle_q) && $stable(elapsed_q))

endmodule
`default_nettype wire

FILE: sv/sms_outq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "servo_motion_sequencer_assert.svh"
module sms_outq (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire sms_pkg::result_t push_data,
	output logic            space,
	output logic            out_valid,
	input  wire logic       out_stall,
	output sms_pkg::result_t head
);
	import sms_pkg::*;

	logic    head_valid_q;
	logic    skid_valid_q;
	result_t head_q;
	result_t skid_q;
	logic    pop;

	assign pop   = head_valid_q && !out_stall;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!head_valid_q) begin
				head_valid_q <= push;
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					head_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!head_valid_q || (pop && !skid_valid_q)) begin
			if (push) begin
				head_q <= push_data;
			end
		end else if (pop) begin
			head_q <= skid_q;
			if (push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = head_valid_q;
	assign head      = head_q;

	`SMS_ASSERT_IMPL(a_skid_behind_head, skid_valid_q, head_valid_q)
	`SMS_ASSERT_IMPL(a_no_overflow, push, !skid_valid_q)

endmodule
`default_nettype wire

FILE: sv/servo_motion_sequencer.sv
// An accepted item is held in the input register; its result is then pushed into the output
// queue and offered from its head; the push waits while that queue is full.
// Throughput: one item per cycle; the input register feeds a two-entry output queue,
// so input is held off only while that queue is full.
// Reset (arst_n low, asynchronous): both channels empty, registers at their defaults,
// arm at the rest angle, program idle, elapsed count zero.
`timescale 1ns / 1ps
`default_nettype none
module servo_motion_sequencer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mode,
	input  wire logic [sms_pkg::PROG_W-1:0]      program_request,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [sms_pkg::ANGLE_W-1:0]          arm_angle,
	output logic                                 angle_written,
	output logic                                 step_finished,
	output logic [sms_pkg::PROG_W-1:0]           program_now
);
	import sms_pkg::*;

	cfg_t              cfg;
	result_t           res;
	result_t           head;
	logic              space;
	logic              proc;
	logic              valid_s1;
	logic              mode_s1;
	logic [PROG_W-1:0] req_s1;

	assign proc     = valid_s1 && space;
	assign in_stall = valid_s1 && !space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			req_s1  <= program_request;
		end
	end

	sms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sms_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.proc            (proc),
		.mode            (mode_s1),
		.program_request (req_s1),
		.cfg             (cfg),
		.res             (res)
	);

	sms_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (proc),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign arm_angle     = head.arm_angle;
	assign angle_written = head.angle_written;
	assign step_finished = head.step_finished;
	assign program_now   = head.program_now;

endmodule
`default_nettype wire
